>>> rtl/core/b64mh_pkg.sv
// Package for the base64 + MurmurHash3 block: queue command type, hash
// constants and the base64 alphabet lookup. No dependencies.
package b64mh_pkg;

    // Default characters per encoded line
    localparam int LINE_CHARS_DEF = 76;
    // Line column width, enough for the largest line length
    localparam int COL_W = 7;
    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // MurmurHash3 x86_32 constants
    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_C3 = 32'he6546b64;
    localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;

    // Special characters of the text stream
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Full group of three bytes in one command
    localparam logic [1:0] NB_FULL = 2'd3;

    // One command from front to back: up to three bytes, left aligned
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  nbytes;
        logic        is_end;
        logic        first;
        logic [31:0] seed;
    } t_cmd;

    // Map a six-bit value to its base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/base64_then_murmur3_hash.sv
// Streaming MurmurHash3 x86_32 of the MIME base64 text of a byte message.
// Top level: front end, command queue, back end. Depends on b64mh_pkg.
//
// Each request carries one raw byte or none (an end request may carry none) and a
// last flag; the request marked last yields one signed 32-bit hash. The front
// end takes one request per cycle while the four-entry command queue has room
// and turns every third byte, and every message end, into a command. The back
// end then fetches each command, emits each encoded character and each inserted
// newline, and closes the command; it works on one command at a time while the
// queue holds the rest. After the last character it closes the command and the
// finalizer steps through S_FK1, S_FK2, S_FX, S_FM1, S_FM2 and S_FOUT, so the
// hash reaches the output register and is held there until accepted; while it
// waits, the next message can be encoded. The seed written on the configuration
// channel is captured by the first byte or end request of each message.
module base64_then_murmur3_hash #(
    parameter int LINE_CHARS = b64mh_pkg::LINE_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_present,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_message_hash,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import b64mh_pkg::*;

    t_cmd        push_cmd;
    t_cmd        head_cmd;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic [31:0] hash;

    assign o_message_hash = $signed(hash);

    // Accept and group bytes
    b64mh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_item    (i_last_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Decouple front and back
    b64mh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Encode, hash and finalize
    b64mh_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hash      (hash)
    );

endmodule

>>> rtl/core/b64mh_front.sv
// Front end: accepts message bytes, groups them by three and pushes commands.
// Holds the seed register. Depends on b64mh_pkg.
module b64mh_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_present,
    input  logic               i_last_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_q_full,
    output logic               o_push,
    output b64mh_pkg::t_cmd    o_cmd
);
    import b64mh_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_msg_seed, n_msg_seed;
    logic [15:0] r_gb, n_gb;
    logic [1:0]  r_fill, n_fill;
    logic        r_started;
    logic        r_pushed;
    logic        eff;
    logic        full_grp;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;

    // Classify the request and build the command
    always_comb begin
        eff        = i_in_valid && o_in_ready && (i_byte_present || i_last_item);
        n_msg_seed = r_started ? r_msg_seed : r_seed;
        full_grp   = i_byte_present && (r_fill == 2'd2);
        n_gb       = r_gb;
        n_fill     = r_fill;
        if (full_grp) begin
            n_fill = 2'd0;
        end else if (i_byte_present) begin
            n_gb   = {r_gb[7:0], i_data_byte};
            n_fill = r_fill + 2'd1;
        end
        o_cmd.is_end = i_last_item;
        o_cmd.first  = !r_pushed;
        o_cmd.seed   = n_msg_seed;
        if (full_grp) begin
            o_cmd.bytes  = {r_gb, i_data_byte};
            o_cmd.nbytes = NB_FULL;
        end else begin
            o_cmd.bytes  = (n_fill == 2'd1) ? {n_gb[7:0], 16'h0000} : {n_gb, 8'h00};
            o_cmd.nbytes = n_fill;
        end
        o_push = eff && (full_grp || i_last_item);
        // Drop the partial group once the message ends
        if (i_last_item) begin
            n_fill = 2'd0;
        end
    end

    // Hold seed and grouping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_msg_seed <= '0;
            r_gb       <= '0;
            r_fill     <= '0;
            r_started  <= 1'b0;
            r_pushed   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (eff) begin
                r_gb       <= n_gb;
                r_fill     <= n_fill;
                r_started  <= !i_last_item;
                r_msg_seed <= n_msg_seed;
                if (o_push) begin
                    r_pushed <= !i_last_item;
                end
            end
        end
    end

endmodule

>>> rtl/core/b64mh_queue.sv
// Short command queue between front and back ends.
// Depends on b64mh_pkg for the command type and depth.
module b64mh_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64mh_pkg::t_cmd    i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output b64mh_pkg::t_cmd    o_cmd
);
    import b64mh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    // Store commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/core/b64mh_back.sv
// Back end: expands commands to base64 text with line breaks, hashes the
// characters with MurmurHash3 x86_32 and finalizes. Depends on b64mh_pkg.
module b64mh_back #(
    parameter int LINE_CHARS = b64mh_pkg::LINE_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  b64mh_pkg::t_cmd    i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_hash
);
    import b64mh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHARS, S_FK1, S_FK2, S_FX, S_FM1, S_FM2, S_FOUT
    } t_state;

    t_state           r_state;
    t_cmd             r_cur;
    logic [2:0]       r_idx, n_idx;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_nl_due, n_nl;
    logic [23:0]      r_pend, n_pend;
    logic [1:0]       r_pc;
    logic [31:0]      r_count;
    logic [31:0]      r_acc;
    logic [31:0]      r_k1, r_k2;
    logic             r_v1, r_v2;
    logic [31:0]      r_fk;
    logic [31:0]      r_h;
    logic [31:0]      r_out;
    logic             r_out_valid;
    logic             emit_en;
    logic [7:0]       emit_c;
    logic             chars_done;
    logic [2:0]       nchars;
    logic [5:0]       sextet;
    logic [31:0]      acc_x;
    logic [31:0]      fx_h;
    logic [31:0]      fm2_h;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_hash      = r_out;

    // Pick the next character of the text stream
    always_comb begin
        nchars     = (r_cur.nbytes == 2'd0) ? 3'd0 : 3'd4;
        case (r_idx[1:0])
            2'd0:    sextet = r_cur.bytes[23:18];
            2'd1:    sextet = r_cur.bytes[17:12];
            2'd2:    sextet = r_cur.bytes[11:6];
            default: sextet = r_cur.bytes[5:0];
        endcase
        emit_en    = 1'b0;
        emit_c     = CHAR_NL;
        n_col      = r_col;
        n_nl       = r_nl_due;
        n_idx      = r_idx;
        chars_done = 1'b0;
        if (r_state == S_CHARS) begin
            if (r_nl_due) begin
                emit_en = 1'b1;
                n_col   = '0;
                n_nl    = 1'b0;
            end else if (r_idx < nchars) begin
                emit_en = 1'b1;
                emit_c  = (r_idx[1:0] > r_cur.nbytes) ? CHAR_PAD : b64_char(sextet);
                n_col   = r_col + 1'b1;
                n_nl    = (n_col == COL_W'(LINE_CHARS));
                n_idx   = r_idx + 3'd1;
            end else if (r_cur.is_end && (r_col != '0)) begin
                // Close a partial last line
                emit_en = 1'b1;
                n_col   = '0;
            end else begin
                chars_done = 1'b1;
            end
        end
        n_pend = r_pend | (24'(emit_c) << {r_pc, 3'b000});
        acc_x  = r_acc ^ r_k2;
        fx_h   = r_acc ^ ((r_pc != 2'd0) ? r_fk : 32'h0) ^ r_count;
        fm2_h  = r_h ^ {13'h0, r_h[31:13]};
    end

    // Sequence characters, the absorb pipeline and the finalizer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_col       <= '0;
            r_nl_due    <= 1'b0;
            r_pend      <= '0;
            r_pc        <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Absorb stages two and three
            r_v2 <= r_v1;
            if (r_v1) begin
                r_k2 <= {r_k1[16:0], r_k1[31:17]} * MUR_C2;
            end
            if (r_v2) begin
                r_acc <= ({acc_x[18:0], acc_x[31:19]} * 32'd5) + MUR_C3;
            end

            // Hash one character, start a block on the fourth
            r_v1 <= 1'b0;
            if (emit_en) begin
                r_count <= r_count + 32'd1;
                if (r_pc == 2'd3) begin
                    r_k1   <= {emit_c, r_pend} * MUR_C1;
                    r_v1   <= 1'b1;
                    r_pend <= '0;
                    r_pc   <= '0;
                end else begin
                    r_pend <= n_pend;
                    r_pc   <= r_pc + 2'd1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cur   <= i_cmd;
                        r_idx   <= '0;
                        r_state <= S_CHARS;
                        if (i_cmd.first) begin
                            r_acc    <= i_cmd.seed;
                            r_count  <= '0;
                            r_col    <= '0;
                            r_nl_due <= 1'b0;
                            r_pend   <= '0;
                            r_pc     <= '0;
                        end
                    end
                end
                S_CHARS: begin
                    r_col    <= n_col;
                    r_nl_due <= n_nl;
                    r_idx    <= n_idx;
                    if (chars_done) begin
                        r_state <= r_cur.is_end ? S_FK1 : S_IDLE;
                    end
                end
                S_FK1: begin
                    r_fk    <= {8'h00, r_pend} * MUR_C1;
                    r_state <= S_FK2;
                end
                S_FK2: begin
                    r_fk    <= {r_fk[16:0], r_fk[31:17]} * MUR_C2;
                    r_state <= S_FX;
                end
                S_FX: begin
                    r_h     <= fx_h ^ {16'h0, fx_h[31:16]};
                    r_state <= S_FM1;
                end
                S_FM1: begin
                    r_h     <= r_h * MUR_F1;
                    r_state <= S_FM2;
                end
                S_FM2: begin
                    r_h     <= fm2_h * MUR_F2;
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_h ^ {16'h0, r_h[31:16]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Blocks are at least four characters apart
    a_absorb_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 && r_v2))
        else $error("absorb pipeline holds two blocks");

    // Finalizer reads the accumulator only after the pipeline drained
    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FX) |-> (!r_v1 && !r_v2))
        else $error("finalizer started with absorb in flight");

    // Column never runs past the line length
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(LINE_CHARS))
        else $error("line column out of range");

    // A due newline means the line is full
    a_nl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nl_due |-> (r_col == COL_W'(LINE_CHARS)))
        else $error("newline due on a partial line");

endmodule

>>> bench/testbench.sv
// Testbench for base64_then_murmur3_hash: sends raw message bytes and seed writes,
// predicts each message hash in place and checks every hash the block returns.
// Depends only on the RTL top level and its package.
module testbench;

    localparam int LINE_LEN      = 76;
    localparam int SETTLE_CYCLES = 100;
    localparam int N_DIRECTED    = 16;

    localparam logic [31:0] K_MUL1 = 32'hcc9e2d51;
    localparam logic [31:0] K_MUL2 = 32'h1b873593;
    localparam logic [31:0] K_ADD  = 32'he6546b64;
    localparam logic [31:0] K_FIN1 = 32'h85ebca6b;
    localparam logic [31:0] K_FIN2 = 32'hc2b2ae35;
    localparam logic [7:0]  NEWLINE  = 8'h0A;
    localparam logic [7:0]  PAD_CHAR = 8'h3D;
    localparam logic [8*64-1:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One directed request; known marks a hash typed in by hand
    typedef struct packed {
        logic [7:0]         data;
        logic               present;
        logic               last;
        logic               known;
        logic signed [31:0] hash;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'hA5, 1'b0, 1'b0, 1'b0, 32'sd0},  // idle request, ignored
        '{8'h5A, 1'b0, 1'b1, 1'b1, 32'sd0},  // empty message, seed zero
        '{8'h00, 1'b1, 1'b1, 1'b0, 32'sd0},  // one byte, two pads
        '{8'hFF, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 32'sd0},  // two bytes, one pad
        '{8'h00, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 32'sd0},  // full group with byte on last
        '{8'h55, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'h3C, 1'b0, 1'b0, 1'b0, 32'sd0},  // idle inside a message
        '{8'hC3, 1'b0, 1'b1, 1'b0, 32'sd0},  // end without a byte
        '{8'h01, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'hFE, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'h7F, 1'b1, 1'b0, 1'b0, 32'sd0},
        '{8'h10, 1'b1, 1'b0, 1'b0, 32'sd0}   // left open across a seed write
    };

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [7:0]         i_data_byte    = 8'h00;
    logic               i_byte_present = 1'b0;
    logic               i_last_item    = 1'b0;
    logic               i_out_ready    = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic [31:0]        i_cfg_data     = 32'h0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_cfg_ready;
    logic signed [31:0] o_message_hash;

    int send_gap_pct   = 28;
    int recv_stall_pct = 84;
    int error_count    = 0;

    logic signed [31:0] expected_hashes [$];
    logic signed [31:0] want_hash;

    // Predicted block state
    logic [31:0] seed_reg    = 32'h0;
    logic [15:0] held_bytes  = 16'h0;
    logic [1:0]  held_count  = 2'd0;
    int          line_pos    = 0;
    logic [31:0] block_bytes = 32'h0;
    int          block_fill  = 0;
    logic [31:0] mix_state   = 32'h0;
    logic [31:0] text_length = 32'h0;
    logic        msg_open    = 1'b0;

    base64_then_murmur3_hash #(
        .LINE_CHARS (LINE_LEN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_item    (i_last_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_message_hash (o_message_hash),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] mix_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_MUL1;
        t = rotl32(t, 15);
        return t * K_MUL2;
    endfunction

    function automatic logic [7:0] b64_sym(input logic [5:0] idx);
        return B64_SYMBOLS[8*(63 - idx) +: 8];
    endfunction

    // Append one character to the hash stream, absorbing each full word
    function automatic void absorb_char(input logic [7:0] c);
        block_bytes = block_bytes | ({24'h0, c} << (8 * block_fill));
        block_fill++;
        text_length = text_length + 32'd1;
        if (block_fill == 4) begin
            mix_state = mix_state ^ mix_block(block_bytes);
            mix_state = rotl32(mix_state, 13);
            mix_state = mix_state * 32'd5 + K_ADD;
            block_bytes = 32'h0;
            block_fill = 0;
        end
    endfunction

    // Emit one encoded character and wrap the line when it is full
    function automatic void emit_text_char(input logic [7:0] c);
        absorb_char(c);
        line_pos++;
        if (line_pos >= LINE_LEN) begin
            absorb_char(NEWLINE);
            line_pos = 0;
        end
    endfunction

    // Advance the predicted state by one accepted request; 1 when a hash is due
    function automatic bit predict_hash_request(input logic [7:0] b, input logic p,
                                                input logic l,
                                                output logic signed [31:0] hash);
        logic [23:0] v;
        logic [31:0] h;
        hash = 32'sd0;
        if (!p && !l) return 1'b0;
        if (!msg_open) begin
            mix_state = seed_reg;
            msg_open = 1'b1;
        end
        if (p) begin
            if (held_count == 2'd2) begin
                v = {held_bytes, b};
                emit_text_char(b64_sym(v[23:18]));
                emit_text_char(b64_sym(v[17:12]));
                emit_text_char(b64_sym(v[11:6]));
                emit_text_char(b64_sym(v[5:0]));
                held_bytes = 16'h0;
                held_count = 2'd0;
            end else begin
                held_bytes = {held_bytes[7:0], b};
                held_count = held_count + 2'd1;
            end
        end
        if (!l) return 1'b0;
        // Flush a partial group with padding
        if (held_count == 2'd1) begin
            v = {held_bytes[7:0], 16'h0};
            emit_text_char(b64_sym(v[23:18]));
            emit_text_char(b64_sym(v[17:12]));
            emit_text_char(PAD_CHAR);
            emit_text_char(PAD_CHAR);
        end else if (held_count == 2'd2) begin
            v = {held_bytes, 8'h0};
            emit_text_char(b64_sym(v[23:18]));
            emit_text_char(b64_sym(v[17:12]));
            emit_text_char(b64_sym(v[11:6]));
            emit_text_char(PAD_CHAR);
        end
        if (line_pos != 0) absorb_char(NEWLINE);
        // Tail, length and final avalanche
        h = mix_state;
        if (block_fill != 0) h = h ^ mix_block(block_bytes);
        h = h ^ text_length;
        h = h ^ (h >> 16);
        h = h * K_FIN1;
        h = h ^ (h >> 13);
        h = h * K_FIN2;
        h = h ^ (h >> 16);
        hash = h;
        held_bytes = 16'h0;
        held_count = 2'd0;
        line_pos = 0;
        block_bytes = 32'h0;
        block_fill = 0;
        mix_state = 32'h0;
        text_length = 32'h0;
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    // Send one request, idling first at random, and record its hash if due
    task automatic push_request(input logic [7:0] b, input logic p, input logic l,
                                input logic known, input logic signed [31:0] known_hash);
        logic signed [31:0] h;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= p;
        i_last_item    <= l;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_hash_request(b, p, l, h))
            expected_hashes.push_back(known ? known_hash : h);
    endtask

    // Write the seed register and take it into the predictor
    task automatic write_seed(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every hash, then let the back end go quiet
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Whole messages of random bytes, with idle requests scattered in
    task automatic run_random_phase(input int min_items, input int min_msgs);
        int items_sent;
        int msgs_done;
        int msg_len;
        int pick;
        bit split_end;
        items_sent = 0;
        msgs_done = 0;
        while (items_sent < min_items || msgs_done < min_msgs) begin
            pick = $urandom_range(99);
            if (pick < 8)       msg_len = 0;
            else if (pick < 80) msg_len = $urandom_range(12, 1);
            else if (pick < 95) msg_len = $urandom_range(64, 50);
            else                msg_len = $urandom_range(200, 100);
            split_end = (msg_len == 0) || ($urandom_range(1) == 1);
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(99) < 8)
                    push_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 32'sd0);
                push_request(8'($urandom_range(255)), 1'b1,
                             !split_end && (k == msg_len - 1), 1'b0, 32'sd0);
                items_sent++;
            end
            if (split_end) begin
                push_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 32'sd0);
                items_sent++;
            end
            msgs_done++;
        end
    endtask

    // Randomize receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every returned hash with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: unexpected hash, expected none, got %0d",
                         $time, o_message_hash);
                error_count++;
            end else begin
                want_hash = expected_hashes.pop_front();
                if (o_message_hash !== want_hash) begin
                    $display("%0t: message hash expected %0d, got %0d",
                             $time, want_hash, o_message_hash);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_seed(32'h0000_0000);

        // Walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            push_request(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present,
                         DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].known,
                         DIRECTED_ROWS[r].hash);
        end

        // New seed lands mid-message and must wait for the next one
        settle_block();
        write_seed(32'hFFFF_FFFF);
        run_random_phase(170, 8);

        settle_block();
        write_seed($urandom);
        send_gap_pct   = 84;
        recv_stall_pct = 28;
        run_random_phase(170, 8);

        settle_block();
        write_seed(32'h8000_0000);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random_phase(170, 8);

        settle_block();
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
